FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

FILE: hdl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// types and codes of the bounded message fifo
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

    localparam int LEN_W = 10;

    localparam logic [1:0] REQ_OPEN  = 2'd0;
    localparam logic [1:0] REQ_CLOSE = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_BLOCK = 2'd1;
    localparam logic [1:0] STAT_NONE  = 2'd2;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]       req_type;
        logic             open_for_read;
        logic             open_for_write;
        logic [63:0]      data_word;
        logic [LEN_W-1:0] byte_count;
        logic             last_beat;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [63:0]      data_word_res;
        logic [3:0]       word_bytes;
        logic [LEN_W-1:0] item_length;
        logic             last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_RD_LEN,
        ST_RD_DATA
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/bounded_message_fifo.sv
// ----------------------------------------------------------------------------
// bounded_message_fifo
// ring of message slots with reader and writer handle counts
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   i_start / o_busy     i_req  (t_req)
//  result    o_res_valid strobe   o_res  (t_res)
//
//  open, close, rejected or dropped write beat, non-final write beat: busy stays low
//  final write beat: busy through ST_FLUSH when the message tail straddles a word
//  read: ST_RD_LEN, then ST_RD_DATA per word of the n bytes returned (none
//  when n is zero), set by the registered reads of length ram, then slot ram
//  results show in the cycle after they are formed; the receiver cannot stall
//  synchronous active-low reset, no clearing pass: ram contents are used only
//  after they are written
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bounded_message_fifo
    import bmf_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int ITEM_BYTES = 512
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    input  wire t_req i_req,
    output logic      o_res_valid,
    output t_res      o_res
);

    localparam int SW     = (ITEM_BYTES + 7) / 8;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int DEPTH  = SLOTS * SW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = $clog2(SW + 1);

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [SLOT_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [7:0]          r_readers, n_readers;
    logic [7:0]          r_writers, n_writers;
    logic [LEN_W-1:0]    r_fill, n_fill;
    logic                r_rejected, n_rejected;
    logic                r_res_valid, n_res_valid;
    logic [63:0]         r_acc, n_acc;
    logic [LEN_W-1:0]    r_limit, n_limit;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [ADDR_W-1:0]   r_flush_addr, n_flush_addr;
    t_res                r_res, n_res;

    logic                accept;
    logic [3:0]          beat_cap;
    logic [LEN_W-1:0]    room;
    logic [3:0]          beat_n;
    logic [2:0]          sh;
    logic [63:0]         acc_eff;
    logic [127:0]        merged;
    logic [LEN_W-1:0]    new_fill;
    logic [3:0]          end_pos;
    logic                crossed;
    logic [WORD_W-1:0]   fill_word;
    logic [LEN_W-1:0]    rd_len;
    logic [LEN_W-1:0]    rd_n;
    logic [3:0]          rd_wb;

    logic                st_we;
    logic [ADDR_W-1:0]   st_waddr;
    logic [63:0]         st_wdata;
    logic                st_re;
    logic [ADDR_W-1:0]   st_raddr;
    logic [63:0]         st_rdata;
    logic                ln_we;
    logic [LEN_W-1:0]    ln_rdata;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [WORD_W-1:0] word);
        return ADDR_W'(slot) * ADDR_W'(SW) + ADDR_W'(word);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        return (slot == SLOT_W'(SLOTS - 1)) ? '0 : slot + 1'b1;
    endfunction

    assign accept = i_start && (r_state == ST_IDLE);

    // write beat packing
    assign beat_cap  = (i_req.byte_count > LEN_W'(8)) ? 4'd8 : i_req.byte_count[3:0];
    assign room      = LEN_W'(ITEM_BYTES) - r_fill;
    assign beat_n    = (LEN_W'(beat_cap) > room) ? room[3:0] : beat_cap;
    assign sh        = r_fill[2:0];
    assign acc_eff   = (sh == 3'd0) ? 64'd0 : r_acc;
    assign merged    = {64'd0, acc_eff}
                     | ({64'd0, i_req.data_word & byte_mask(beat_n)} << {sh, 3'b000});
    assign new_fill  = r_fill + LEN_W'(beat_n);
    assign end_pos   = {1'b0, sh} + beat_n;
    assign crossed   = end_pos[3];
    assign fill_word = WORD_W'(r_fill >> 3);

    // read sizing
    assign rd_len = ln_rdata;
    assign rd_n   = (r_limit < rd_len) ? r_limit : rd_len;
    assign rd_wb  = (r_rem >= LEN_W'(8)) ? 4'd8 : r_rem[3:0];

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_readers    = r_readers;
        n_writers    = r_writers;
        n_fill       = r_fill;
        n_rejected   = r_rejected;
        n_acc        = r_acc;
        n_limit      = r_limit;
        n_rem        = r_rem;
        n_len        = r_len;
        n_word       = r_word;
        n_flush_addr = r_flush_addr;
        n_res_valid  = 1'b0;
        n_res        = '0;
        n_res.last   = 1'b1;
        st_we        = 1'b0;
        st_waddr     = slot_addr(r_tail, fill_word);
        st_wdata     = merged[63:0];
        st_re        = 1'b0;
        st_raddr     = slot_addr(r_head, r_word);
        ln_we        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        REQ_OPEN: begin
                            if (i_req.open_for_read && r_readers != COUNT_MAX) begin
                                n_readers = r_readers + 8'd1;
                            end
                            if (i_req.open_for_write && r_writers != COUNT_MAX) begin
                                n_writers = r_writers + 8'd1;
                            end
                            n_res_valid = 1'b1;
                        end
                        REQ_CLOSE: begin
                            if (i_req.open_for_read && r_readers != 8'd0) begin
                                n_readers = r_readers - 8'd1;
                            end
                            if (i_req.open_for_write && r_writers != 8'd0) begin
                                n_writers = r_writers - 8'd1;
                            end
                            n_res_valid = 1'b1;
                        end
                        REQ_WRITE: begin
                            if (r_rejected) begin
                                if (i_req.last_beat) begin
                                    n_rejected = 1'b0;
                                end
                            end else if (r_fill == '0 && r_count == CNT_W'(SLOTS)) begin
                                n_res_valid   = 1'b1;
                                n_res.status  = (r_readers != 8'd0) ? STAT_BLOCK : STAT_NONE;
                                if (!i_req.last_beat) begin
                                    n_rejected = 1'b1;
                                end
                            end else begin
                                st_we  = crossed || (i_req.last_beat
                                                     && (beat_n != 4'd0 || sh != 3'd0));
                                n_acc  = crossed ? merged[127:64] : merged[63:0];
                                n_fill = new_fill;
                                if (i_req.last_beat) begin
                                    ln_we             = 1'b1;
                                    n_tail            = slot_inc(r_tail);
                                    n_count           = r_count + 1'b1;
                                    n_fill            = '0;
                                    n_res_valid       = 1'b1;
                                    n_res.item_length = new_fill;
                                    if (crossed && new_fill[2:0] != 3'd0) begin
                                        n_flush_addr = slot_addr(r_tail,
                                                                 WORD_W'(fill_word + 1'b1));
                                        n_state      = ST_FLUSH;
                                    end
                                end
                            end
                        end
                        REQ_READ: begin
                            if (r_count == '0) begin
                                n_res_valid  = 1'b1;
                                n_res.status = (r_writers != 8'd0) ? STAT_BLOCK : STAT_NONE;
                            end else begin
                                n_limit = i_req.byte_count;
                                n_state = ST_RD_LEN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                st_we    = 1'b1;
                st_waddr = r_flush_addr;
                st_wdata = r_acc;
                n_state  = ST_IDLE;
            end
            ST_RD_LEN: begin
                if (rd_n == '0) begin
                    n_res_valid       = 1'b1;
                    n_res.item_length = rd_len;
                    n_head            = slot_inc(r_head);
                    n_count           = r_count - 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    n_rem    = rd_n;
                    n_len    = rd_len;
                    st_re    = 1'b1;
                    st_raddr = slot_addr(r_head, '0);
                    n_word   = WORD_W'(1);
                    n_state  = ST_RD_DATA;
                end
            end
            ST_RD_DATA: begin
                n_res_valid         = 1'b1;
                n_res.data_word_res = st_rdata & byte_mask(rd_wb);
                n_res.word_bytes    = rd_wb;
                n_res.item_length   = r_len;
                n_res.last          = (r_rem <= LEN_W'(8));
                if (r_rem <= LEN_W'(8)) begin
                    n_head  = slot_inc(r_head);
                    n_count = r_count - 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_rem  = r_rem - LEN_W'(8);
                    st_re  = 1'b1;
                    n_word = r_word + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_readers   <= '0;
            r_writers   <= '0;
            r_fill      <= '0;
            r_rejected  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_readers   <= n_readers;
            r_writers   <= n_writers;
            r_fill      <= n_fill;
            r_rejected  <= n_rejected;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_limit      <= n_limit;
        r_rem        <= n_rem;
        r_len        <= n_len;
        r_word       <= n_word;
        r_flush_addr <= n_flush_addr;
        r_res        <= n_res;
    end

    bmf_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    bmf_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_waddr (r_tail),
        .i_wdata (new_fill),
        .i_re    (1'b1),
        .i_raddr (r_head),
        .o_rdata (ln_rdata)
    );

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(SLOTS), "item count above ring size")
    `ASSERT_NEVER(a_reject_clean, i_clk, i_rst_n, r_rejected && (r_fill != '0), "dropping while filling")
    `ASSERT_CLK(a_rd_word_out, i_clk, i_rst_n, (r_state == ST_RD_DATA) |=> o_res_valid, "read word lost")
    `ASSERT_CLK(a_flush_once, i_clk, i_rst_n, (r_state == ST_FLUSH) |=> (r_state == ST_IDLE), "flush stuck")

endmodule

`default_nettype wire

FILE: hdl/bmf_ram.sv
// ----------------------------------------------------------------------------
// bmf_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
